[design/tsrs_pkg.sv]
// Shared types and constants for the timed step report sequencer.
package tsrs_pkg;

	localparam int TIME_W = 32;	// millisecond time and durations
	localparam int CNT_W  = 5;	// step count register
	localparam int PTR_W  = 5;	// step pointer, below the effective count
	localparam int N_W    = 7;	// transition counter, up to 2*31+2
	localparam int SLOT_W = 4;	// table slot field
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HOLD = 2'd1,
		PH_WAIT = 2'd2,
		PH_GAP  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CFG_ACTIVE_STEPS  = 2'd0,
		CFG_ROUND_GAP     = 2'd1,
		CFG_REPEAT_ROUNDS = 2'd2,
		CFG_NEUTRAL_WORD  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_EVAL,
		S_EMIT
	} seq_state_t;

	// result of the shared time compare unit
	typedef struct packed {
		logic              ge;		// elapsed >= phase length
		logic [TIME_W-1:0] rem;		// length - elapsed, valid when !ge
		logic [TIME_W-1:0] next_start;	// phase start + length
	} time_res_t;

endpackage

[design/timed_step_report_sequencer.sv]
// Top level of the timed step report sequencer: control sequencer, step table and time unit.
//
// Usage: items arrive on the input channel (in_valid/in_ready) with an operation code:
// write a step into the table, start at now_ms, stop, or tick with the current time.
// Every item yields exactly one status transaction on the output channel
// (out_valid/out_ready): report word, changed flag, phase, step, round count and the
// time left in the current phase.
// Registers are written through the cfg channel (cfg_valid/cfg_ready, always ready); the user must
// write them only while no item is in flight, which the block itself does not enforce.
// Steps: execute, table read, one evaluate per phase transition caught up (at most
// 2*count+2) plus a closing evaluate, then the output register load. The evaluate loop
// steps one transition per cycle through the shared time unit and the table RAM's
// registered read port.
// One item is worked at a time; in_ready is high only when the sequencer is idle.
// A finished status waits in the output register, and the next item is taken meanwhile;
// a second status waits in the sequencer until the receiver drains the first.
// Reset: idle, neutral word zero, counters cleared; the table holds nothing defined
// until written.
module timed_step_report_sequencer #(
	parameter int MAX_STEPS = 16,
	parameter int WORD_BITS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsrs_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       operation,
	input  logic [tsrs_pkg::TIME_W-1:0]      now_ms,
	input  logic [tsrs_pkg::SLOT_W-1:0]      step_slot,
	input  logic [WORD_BITS-1:0]             step_word,
	input  logic [tsrs_pkg::TIME_W-1:0]      step_hold_ms,
	input  logic [tsrs_pkg::TIME_W-1:0]      step_pause_ms,
	// output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [WORD_BITS-1:0]             out_word,
	output logic                             word_changed,
	output logic                             active,
	output logic [1:0]                       phase_code,
	output logic [3:0]                       current_step,
	output logic [tsrs_pkg::TIME_W-1:0]      rounds_done,
	output logic [tsrs_pkg::TIME_W-1:0]      remaining_ms
);
	import tsrs_pkg::*;

	localparam int AW      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int ENTRY_W = WORD_BITS + 2 * TIME_W;
	localparam int CNT_CAP = (MAX_STEPS > 31) ? 31 : MAX_STEPS;

	// configuration registers
	logic [CNT_W-1:0]     active_steps_q;
	logic [TIME_W-1:0]    round_gap_q;
	logic                 repeat_q;
	logic [WORD_BITS-1:0] neutral_q;

	// latched input transaction
	op_t                  op_q;
	logic [TIME_W-1:0]    now_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [WORD_BITS-1:0] sword_q;
	logic [TIME_W-1:0]    shold_q;
	logic [TIME_W-1:0]    spause_q;

	// sequencer state
	seq_state_t           state_q, state_d;
	logic                 run_q, run_d;
	phase_t               phase_q, phase_d;
	logic [PTR_W-1:0]     ptr_q, ptr_d;
	logic [TIME_W-1:0]    start_q, start_d;
	logic [TIME_W-1:0]    round_q, round_d;
	logic [WORD_BITS-1:0] word_q, word_d;
	logic                 chg_q, chg_d;
	logic                 pend_q, pend_d;	// word of entry at ptr still to be applied
	logic                 loop_q, loop_d;	// tick catch-up still running
	logic [N_W-1:0]       n_q, n_d;	// transitions made by this tick
	logic [TIME_W-1:0]    rem_q, rem_d;
	logic                 ram_we;
	logic                 load_out;

	// output register
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic                 out_chg_q;
	logic                 out_run_q;
	phase_t               out_phase_q;
	logic [3:0]           out_step_q;
	logic [TIME_W-1:0]    out_round_q;
	logic [TIME_W-1:0]    out_rem_q;

	// table and time unit
	logic [ENTRY_W-1:0]   rd_data;
	logic [WORD_BITS-1:0] rd_word;
	logic [TIME_W-1:0]    rd_hold;
	logic [TIME_W-1:0]    rd_pause;
	logic [TIME_W-1:0]    len;
	time_res_t            tu;
	logic [CNT_W-1:0]     eff;
	logic [N_W-1:0]       limit;
	logic                 slot_ok;
	logic                 in_acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_steps_q <= '0;
			round_gap_q    <= '0;
			repeat_q       <= 1'b0;
			neutral_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ACTIVE_STEPS:  active_steps_q <= cfg_data[CNT_W-1:0];
				CFG_ROUND_GAP:     round_gap_q    <= cfg_data[TIME_W-1:0];
				CFG_REPEAT_ROUNDS: repeat_q       <= cfg_data[0];
				CFG_NEUTRAL_WORD:  neutral_q      <= cfg_data[WORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input transaction capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= op_t'(operation);
			now_q    <= now_ms;
			slot_q   <= step_slot;
			sword_q  <= step_word;
			shold_q  <= step_hold_ms;
			spause_q <= step_pause_ms;
		end
	end

	// count saturates to the table size, and to 31 at most
	assign eff     = (active_steps_q > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : active_steps_q;
	assign limit   = N_W'({eff, 1'b0}) + N_W'(2);
	assign slot_ok = (32'(slot_q) < MAX_STEPS);

	// step table: word, hold, pause per entry; read address follows the next pointer
	tsrs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_STEPS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(slot_q)),
		.wdata ({sword_q, shold_q, spause_q}),
		.raddr (AW'(ptr_d)),
		.rdata (rd_data)
	);

	assign rd_word  = rd_data[ENTRY_W-1 -: WORD_BITS];
	assign rd_hold  = rd_data[2*TIME_W-1 -: TIME_W];
	assign rd_pause = rd_data[TIME_W-1:0];

	always_comb begin
		case (phase_q)
			PH_HOLD: len = rd_hold;
			PH_WAIT: len = rd_pause;
			PH_GAP:  len = round_gap_q;
			default: len = TIME_W'(1);
		endcase
	end

	tsrs_time_unit u_time (
		.now_ms   (now_q),
		.start_ms (start_q),
		.len_ms   (len),
		.res      (tu)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			run_q   <= 1'b0;
			phase_q <= PH_IDLE;
			ptr_q   <= '0;
			start_q <= '0;
			round_q <= '0;
			word_q  <= '0;
			chg_q   <= 1'b0;
			pend_q  <= 1'b0;
			loop_q  <= 1'b0;
			n_q     <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			run_q   <= run_d;
			phase_q <= phase_d;
			ptr_q   <= ptr_d;
			start_q <= start_d;
			round_q <= round_d;
			word_q  <= word_d;
			chg_q   <= chg_d;
			pend_q  <= pend_d;
			loop_q  <= loop_d;
			n_q     <= n_d;
			rem_q   <= rem_d;
		end
	end

	// sequencer: next state and datapath control
	always_comb begin
		logic [WORD_BITS-1:0] cur_word;
		logic                 cur_chg;
		logic [N_W-1:0]       n_inc;

		state_d  = state_q;
		run_d    = run_q;
		phase_d  = phase_q;
		ptr_d    = ptr_q;
		start_d  = start_q;
		round_d  = round_q;
		word_d   = word_q;
		chg_d    = chg_q;
		pend_d   = pend_q;
		loop_d   = loop_q;
		n_d      = n_q;
		rem_d    = rem_q;
		ram_we   = 1'b0;
		load_out = 1'b0;
		cur_word = word_q;
		cur_chg  = chg_q;
		n_inc    = n_q + N_W'(1);

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				n_d    = '0;
				loop_d = 1'b0;
				case (op_q)
					OP_WRITE: ram_we = slot_ok;
					OP_START: begin
						round_d = '0;
						ptr_d   = '0;
						start_d = now_q;
						if (eff == '0) begin
							run_d   = 1'b0;
							phase_d = PH_IDLE;
							pend_d  = 1'b0;
							if (neutral_q != word_q) begin
								word_d = neutral_q;
								chg_d  = 1'b1;
							end
						end else begin
							run_d   = 1'b1;
							phase_d = PH_HOLD;
							pend_d  = 1'b1;	// step 0 word lands in evaluate
							chg_d   = 1'b1;
						end
					end
					OP_STOP: begin
						run_d   = 1'b0;
						phase_d = PH_IDLE;
						ptr_d   = '0;
						pend_d  = 1'b0;
						word_d  = neutral_q;
						chg_d   = 1'b1;
					end
					OP_TICK: loop_d = 1'b1;
					default: ;
				endcase
				state_d = S_READ;
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				// apply the word of a step entered on the previous transition
				if (pend_q) begin
					if (rd_word != cur_word) begin
						cur_word = rd_word;
						cur_chg  = 1'b1;
					end
					pend_d = 1'b0;
				end
				if (loop_q && run_q && tu.ge) begin
					// one phase transition
					case (phase_q)
						PH_GAP: begin
							phase_d = PH_HOLD;
							ptr_d   = '0;
							pend_d  = 1'b1;
						end
						default: begin
							if (phase_q == PH_HOLD && rd_pause != '0) begin
								phase_d = PH_WAIT;
								if (neutral_q != cur_word) begin
									cur_word = neutral_q;
									cur_chg  = 1'b1;
								end
							end else if (({1'b0, ptr_q} + 6'd1) < {1'b0, eff}) begin
								phase_d = PH_HOLD;
								ptr_d   = ptr_q + PTR_W'(1);
								pend_d  = 1'b1;
							end else begin
								round_d = round_q + TIME_W'(1);
								ptr_d   = '0;
								if (!repeat_q) begin
									run_d   = 1'b0;
									phase_d = PH_IDLE;
									if (neutral_q != cur_word) begin
										cur_word = neutral_q;
										cur_chg  = 1'b1;
									end
								end else if (round_gap_q != '0) begin
									phase_d = PH_GAP;
									if (neutral_q != cur_word) begin
										cur_word = neutral_q;
										cur_chg  = 1'b1;
									end
								end else begin
									phase_d = PH_HOLD;
									pend_d  = 1'b1;
								end
							end
						end
					endcase
					n_d = n_inc;
					// transition budget used up: resync phase start to now
					if (n_inc >= limit) begin
						start_d = now_q;
						loop_d  = 1'b0;
					end else begin
						start_d = tu.next_start;
					end
				end else begin
					rem_d   = (run_q && !tu.ge) ? tu.rem : '0;
					state_d = S_EMIT;
				end
				word_d = cur_word;
				chg_d  = cur_chg;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					chg_d    = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q  <= word_q;
			out_chg_q   <= chg_q;
			out_run_q   <= run_q;
			out_phase_q <= phase_q;
			out_step_q  <= ptr_q[3:0];
			out_round_q <= round_q;
			out_rem_q   <= rem_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_word     = out_word_q;
	assign word_changed = out_chg_q;
	assign active       = out_run_q;
	assign phase_code   = out_phase_q;
	assign current_step = out_step_q;
	assign rounds_done  = out_round_q;
	assign remaining_ms = out_rem_q;

endmodule

[design/tsrs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsrs_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/tsrs_time_unit.sv]
// Shared wrapping-time compare unit: elapsed time, remaining time, next phase start.
module tsrs_time_unit (
	input  logic [tsrs_pkg::TIME_W-1:0] now_ms,
	input  logic [tsrs_pkg::TIME_W-1:0] start_ms,
	input  logic [tsrs_pkg::TIME_W-1:0] len_ms,
	output tsrs_pkg::time_res_t         res
);
	import tsrs_pkg::*;

	logic [TIME_W-1:0] elapsed;

	assign elapsed        = now_ms - start_ms;	// wraps mod 2^32
	assign res.ge         = (elapsed >= len_ms);
	assign res.rem        = len_ms - elapsed;
	assign res.next_start = start_ms + len_ms;

endmodule
